// ===== hw/rtl/pchg_pkg.sv =====
package pchg_pkg;

  localparam int GRID_SIZE_DEF = 101;

  localparam int COORD_W = 14;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_VERT_LOW  = 2'd0;
  localparam logic [1:0] REG_VERT_HIGH = 2'd1;
  localparam logic [1:0] REG_ROW_ORG   = 2'd2;
  localparam logic [1:0] REG_COL_ORG   = 2'd3;

  localparam logic signed [14:0] VERT_LOW_RESET  = -15'sd1000;
  localparam logic signed [14:0] VERT_HIGH_RESET = 15'sd700;
  localparam logic signed [10:0] ROW_ORG_RESET   = 11'sd200;
  localparam logic signed [10:0] COL_ORG_RESET   = 11'sd100;
  localparam logic signed [14:0] TOP_RESET       = 15'h4000;

  // floor(x / 10) as (x * DIV10_MUL) >> 19, exact for x below 43690
  localparam logic [31:0] DIV10_MUL = 32'd52429;
  // mm + 5 + 16380 keeps the dividend positive; 16380 / 10 is taken off after
  localparam logic [15:0] MM_BIAS = 16'd16385;
  localparam logic signed [COORD_W-1:0] CM_BIAS = 14'sd1638;

  typedef struct packed {
    logic              valid;
    logic signed [14:0] lowest;
  } cell_t;

endpackage

// ===== hw/rtl/pchg_cell_ram.sv =====
module pchg_cell_ram #(
  parameter int DEPTH  = pchg_pkg::GRID_SIZE_DEF * pchg_pkg::GRID_SIZE_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pchg_pkg::cell_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pchg_pkg::cell_t     rd_data
);

  pchg_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/point_cloud_height_grid.sv =====
// Height grid over one frame of points.
// Input stream s_*: s_tuser carries the action (clear, point, read); s_tdata carries
// the point in millimetres and the cell to read. Output stream m_*: one transfer per
// read, with the cell height in centimetres and the occupied flag. Configuration is a
// plain write port (cfg_wr_en, cfg_index, cfg_wr_data) for the vertical pass limits and
// the grid origin; write it only while the block is idle.
// A kept point passes the accept cycle, the planning state and four cell slots; each slot
// that targets a cell in the grid reads it from the cell memory, and the write follows in
// the next cycle if the cell is empty or the point is lower; the last write overlaps the
// next accept cycle. A point outside the pass window returns to idle after planning.
// A read goes from its accept cycle through the memory read state to the response state,
// which waits for the output register to be free, then fills it and raises m_tvalid.
// A clear sweeps the grid with one memory write per cell through the single write port.
// After reset the same sweep empties the grid; s_tready stays low until it is done.
// The result sits in the output register until taken; a following clear or point is
// still accepted, while a further read waits in its response cycle until the output
// register is free.
module point_cloud_height_grid #(
  parameter int GRID_SIZE = pchg_pkg::GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,     // lateral_mm, vertical_mm, forward_mm, row, col
  input  logic [1:0]  s_tuser,     // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,     // height_cm, occupied
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wr_data
);

  localparam int CELLS  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(GRID_SIZE);
  localparam int CW     = pchg_pkg::COORD_W;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(CELLS - 1);
  localparam logic signed [CW-1:0] GRID_S = CW'(GRID_SIZE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PLAN = 3'd1;
  localparam logic [2:0] S_CELL = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  function automatic logic [11:0] div_cm(input logic [14:0] mm);
    logic [15:0] u;
    logic [31:0] p;
    u = {mm[14], mm} + pchg_pkg::MM_BIAS;
    p = 32'(u) * pchg_pkg::DIV10_MUL;
    return p[30:19];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] r, input logic [7:0] c);
    return ADDR_W'(32'(r) * GRID_SIZE + 32'(c));
  endfunction

  function automatic logic in_grid(input logic signed [CW-1:0] x);
    return !x[CW-1] && (x < GRID_S);
  endfunction

  logic [2:0] state;

  logic signed [14:0] vert_low;
  logic signed [14:0] vert_high;
  logic signed [10:0] row_org;
  logic signed [10:0] col_org;
  logic signed [14:0] frame_top;

  logic signed [14:0] vert;
  logic [11:0] q_fwd;
  logic [11:0] q_lat;
  logic [6:0]  rd_row;
  logic [6:0]  rd_col;

  logic [IDX_W-1:0] r_lo, r_hi, c_lo, c_hi;
  logic [1:0] rok, cok;
  logic [1:0] slot;
  logic       rd_ok;

  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;

  logic [ADDR_W-1:0] clr_addr;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  pchg_pkg::cell_t   wr_data, rd_data;

  logic signed [CW-1:0] fcm, lat_cm, tr, tc, r0, r1, c0, c1;
  logic keep;
  logic slot_ok;
  logic rd_in_range;
  logic s_fire;
  logic out_free;
  logic occ;
  logic signed [15:0] diff;
  logic [15:0] diff_r;
  logic [31:0] hprod;
  logic [11:0] height;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // planning: target rows and columns of the point, and the vertical pass test
  always_comb begin
    fcm    = $signed({2'b00, q_fwd}) - pchg_pkg::CM_BIAS;
    lat_cm = $signed({2'b00, q_lat}) - pchg_pkg::CM_BIAS;
    tr     = $signed({{(CW-11){row_org[10]}}, row_org}) - fcm;
    tc     = $signed({{(CW-11){col_org[10]}}, col_org}) + lat_cm;
    r0     = tr >>> 1;
    r1     = r0 + CW'(1);
    c0     = tc >>> 1;
    c1     = c0 + CW'(1);
    keep   = (vert >= vert_low) && (vert <= vert_high);
  end

  assign slot_ok     = rok[slot[1]] && cok[slot[0]];
  assign rd_in_range = (int'(rd_row) < GRID_SIZE) && (int'(rd_col) < GRID_SIZE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr(8'(rd_row), 8'(rd_col));
    if (state == S_CELL) begin
      rd_en   = slot_ok;
      rd_addr = cell_addr(8'(slot[1] ? r_hi : r_lo), 8'(slot[0] ? c_hi : c_lo));
    end else if (state == S_RD) begin
      rd_en = rd_in_range;
    end
  end

  always_comb begin
    if (state == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = pend_valid && (!rd_data.valid || (vert < rd_data.lowest));
      wr_addr = pend_addr;
      wr_data = '{valid: 1'b1, lowest: vert};
    end
  end

  // height of the read cell
  always_comb begin
    occ    = rd_ok && rd_data.valid;
    diff   = {frame_top[14], frame_top} - {rd_data.lowest[14], rd_data.lowest};
    diff_r = 16'(diff) + 16'd5;
    hprod  = 32'(diff_r) * pchg_pkg::DIV10_MUL;
    height = (occ && !diff[15] && (diff != 16'sd0)) ? hprod[30:19] : 12'd0;
  end

  pchg_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_low  <= pchg_pkg::VERT_LOW_RESET;
      vert_high <= pchg_pkg::VERT_HIGH_RESET;
      row_org   <= pchg_pkg::ROW_ORG_RESET;
      col_org   <= pchg_pkg::COL_ORG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pchg_pkg::REG_VERT_LOW:  vert_low  <= cfg_wr_data;
        pchg_pkg::REG_VERT_HIGH: vert_high <= cfg_wr_data;
        pchg_pkg::REG_ROW_ORG:   row_org   <= cfg_wr_data[10:0];
        pchg_pkg::REG_COL_ORG:   col_org   <= cfg_wr_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      frame_top  <= pchg_pkg::TOP_RESET;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      slot       <= '0;
    end else begin
      pend_valid <= (state == S_CELL) && slot_ok;
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            case (s_tuser)
              pchg_pkg::ACT_CLEAR: begin
                state     <= S_CLR;
                clr_addr  <= '0;
                frame_top <= pchg_pkg::TOP_RESET;
              end
              pchg_pkg::ACT_POINT: state <= S_PLAN;
              pchg_pkg::ACT_READ:  state <= S_RD;
              default: ;
            endcase
          end
        end
        S_PLAN: begin
          slot <= '0;
          if (keep) begin
            state <= S_CELL;
            if (vert > frame_top) begin
              frame_top <= vert;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_CELL: begin
          slot <= slot + 2'd1;
          if (slot == 2'd3) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      vert   <= s_tdata[29:15];
      q_lat  <= div_cm(s_tdata[14:0]);
      q_fwd  <= div_cm(s_tdata[44:30]);
      rd_row <= s_tdata[51:45];
      rd_col <= s_tdata[58:52];
    end
    if (state == S_PLAN) begin
      r_lo <= r0[IDX_W-1:0];
      r_hi <= r1[IDX_W-1:0];
      c_lo <= c0[IDX_W-1:0];
      c_hi <= c1[IDX_W-1:0];
      rok  <= {tr[0] && in_grid(r1), in_grid(r0)};
      cok  <= {tc[0] && in_grid(c1), in_grid(c0)};
    end
    if (state == S_CELL) begin
      pend_addr <= rd_addr;
    end
    if (state == S_RD) begin
      rd_ok <= rd_in_range;
    end
    if (state == S_RESP && out_free) begin
      m_tdata <= {3'b000, occ, height};
    end
  end

  a_clr_no_pend: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && state == S_CLR))
    else $error("cell write pending during clear sweep");

  a_port_hazard: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && rd_en) |-> (pend_addr != rd_addr))
    else $error("read and write of the same cell in one cycle");

  a_clear_top: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tuser == pchg_pkg::ACT_CLEAR) |=>
      (frame_top == pchg_pkg::TOP_RESET && state == S_CLR))
    else $error("clear did not restart the frame");

  a_empty_height: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[12]) |-> (m_tdata[11:0] == 12'd0))
    else $error("empty cell reported a height");

endmodule
